@@ rtl/refcounted_grapheme_intern_table_macros.svh @@
// Assertion macros for the grapheme intern table.
`ifndef REFCOUNTED_GRAPHEME_INTERN_TABLE_MACROS_SVH
`define REFCOUNTED_GRAPHEME_INTERN_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define RGIT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check that a condition in the next cycle follows from a trigger.
`define RGIT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define RGIT_ASSERT(lbl, cond, msg)
`define RGIT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/rgit_pkg.sv @@
// Shared types and constants of the grapheme intern table.
`timescale 1ns / 1ps
`default_nettype none
package rgit_pkg;
	localparam int ID_W  = 13;
	localparam int LEN_W = 5;
	localparam int CP_W  = 21;
	localparam int ST_W  = 2;
	localparam int REF_W = 16;

	localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

	localparam logic [1:0] OP_INTERN  = 2'd0;
	localparam logic [1:0] OP_GET     = 2'd1;
	localparam logic [1:0] OP_RETAIN  = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]      op;
		logic [ID_W-1:0] entry_id;
		logic [CP_W-1:0] codepoint;
		logic            last;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [ID_W-1:0]  result_id;
		logic [LEN_W-1:0] length;
		logic [CP_W-1:0]  out_codepoint;
		logic             result_last;
		logic             full_seen;
	} rsp_t;

	typedef struct packed {
		logic            in_load;
		logic            stage_wr;
		logic            clr_staging;
		logic            e_clr;
		logic            e_next;
		logic            e_load_id;
		logic            k_clr;
		logic            k_inc;
		logic            rd_len;
		logic            rd_ref;
		logic            rd_cp;
		logic            rd_stg;
		logic            wr_cp;
		logic            wr_len_ref;
		logic            wr_ref;
		logic            used_inc;
		logic            set_full;
		logic            ld_n;
		logic            emit;
		logic            emit_get;
		logic            emit_id;
		logic [ST_W-1:0] emit_st;
	} cmd_t;

	typedef struct packed {
		logic op_intern;
		logic op_get;
		logic last;
		logic id_valid;
		logic overlong;
		logic count_zero;
		logic e_end;
		logic used_full;
		logic len_eq;
		logic cp_eq;
		logic ref_zero;
		logic k_last_int;
		logic k_last_get;
		logic n_zero;
		logic out_free;
		logic full;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/rgit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rgit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/rgit_ctrl.sv @@
// Sequencing state machine of the grapheme intern table.
`timescale 1ns / 1ps
`default_nettype none
module rgit_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rgit_pkg::sts_t sts,
	output rgit_pkg::cmd_t     cmd
);
	import rgit_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_INT_CHK, S_SRCH_ISSUE, S_SRCH_LEN, S_CMP_ISSUE,
		S_CMP_CHECK, S_FREE_ISSUE, S_FREE_CHECK, S_WR_ISSUE, S_WR_DATA,
		S_GET_LEN, S_GET_N, S_GET_CHK, S_GET_ISSUE, S_GET_EMIT, S_RC_RD,
		S_RC_WR, S_EMIT
	} state_t;

	state_t          state_q, state_d;
	logic [ST_W-1:0] emit_st_q, emit_st_d;
	logic            emit_id_q, emit_id_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		emit_st_d = emit_st_q;
		emit_id_d = emit_id_q;
		cmd.emit_st = emit_st_q;
		cmd.emit_id = emit_id_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.in_load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op_intern) begin
					cmd.stage_wr = 1'b1;
					state_d = sts.last ? S_INT_CHK : S_IDLE;
				end else if (!sts.id_valid) begin
					emit_st_d = ST_INVALID;
					emit_id_d = 1'b0;
					state_d = S_EMIT;
				end else begin
					cmd.e_load_id = 1'b1;
					state_d = sts.op_get ? S_GET_LEN : S_RC_RD;
				end
			end
			S_INT_CHK: begin
				if (sts.overlong || sts.count_zero) begin
					emit_st_d = ST_INVALID;
					emit_id_d = 1'b0;
					state_d = S_EMIT;
				end else begin
					cmd.e_clr = 1'b1;
					state_d = S_SRCH_ISSUE;
				end
			end
			S_SRCH_ISSUE: begin
				if (sts.e_end) begin
					if (sts.used_full) begin
						cmd.e_clr = 1'b1;
						state_d = S_FREE_ISSUE;
					end else begin
						// append at the current end of the pool
						cmd.used_inc = 1'b1;
						cmd.k_clr = 1'b1;
						state_d = S_WR_ISSUE;
					end
				end else begin
					cmd.rd_len = 1'b1;
					state_d = S_SRCH_LEN;
				end
			end
			S_SRCH_LEN: begin
				if (sts.len_eq) begin
					cmd.k_clr = 1'b1;
					state_d = S_CMP_ISSUE;
				end else begin
					cmd.e_next = 1'b1;
					state_d = S_SRCH_ISSUE;
				end
			end
			S_CMP_ISSUE: begin
				cmd.rd_cp = 1'b1;
				cmd.rd_stg = 1'b1;
				state_d = S_CMP_CHECK;
			end
			S_CMP_CHECK: begin
				if (!sts.cp_eq) begin
					cmd.e_next = 1'b1;
					state_d = S_SRCH_ISSUE;
				end else if (sts.k_last_int) begin
					emit_st_d = ST_OK;
					emit_id_d = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd.k_inc = 1'b1;
					state_d = S_CMP_ISSUE;
				end
			end
			S_FREE_ISSUE: begin
				if (sts.e_end) begin
					cmd.set_full = 1'b1;
					emit_st_d = ST_FULL;
					emit_id_d = 1'b0;
					state_d = S_EMIT;
				end else begin
					cmd.rd_ref = 1'b1;
					state_d = S_FREE_CHECK;
				end
			end
			S_FREE_CHECK: begin
				if (sts.ref_zero) begin
					cmd.k_clr = 1'b1;
					state_d = S_WR_ISSUE;
				end else begin
					cmd.e_next = 1'b1;
					state_d = S_FREE_ISSUE;
				end
			end
			S_WR_ISSUE: begin
				cmd.rd_stg = 1'b1;
				state_d = S_WR_DATA;
			end
			S_WR_DATA: begin
				cmd.wr_cp = 1'b1;
				if (sts.k_last_int) begin
					cmd.wr_len_ref = 1'b1;
					emit_st_d = ST_OK;
					emit_id_d = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd.k_inc = 1'b1;
					state_d = S_WR_ISSUE;
				end
			end
			S_GET_LEN: begin
				cmd.rd_len = 1'b1;
				state_d = S_GET_N;
			end
			S_GET_N: begin
				cmd.ld_n = 1'b1;
				cmd.k_clr = 1'b1;
				state_d = S_GET_CHK;
			end
			S_GET_CHK: begin
				if (sts.n_zero) begin
					emit_st_d = ST_OK;
					emit_id_d = 1'b0;
					state_d = S_EMIT;
				end else begin
					state_d = S_GET_ISSUE;
				end
			end
			S_GET_ISSUE: begin
				cmd.rd_cp = 1'b1;
				state_d = S_GET_EMIT;
			end
			S_GET_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_get = 1'b1;
					if (sts.k_last_get) begin
						state_d = S_IDLE;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = S_GET_ISSUE;
					end
				end
			end
			S_RC_RD: begin
				cmd.rd_ref = 1'b1;
				state_d = S_RC_WR;
			end
			S_RC_WR: begin
				cmd.wr_ref = 1'b1;
				emit_st_d = ST_OK;
				emit_id_d = 1'b0;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.clr_staging = sts.op_intern;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			emit_st_q <= ST_OK;
			emit_id_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			emit_st_q <= emit_st_d;
			emit_id_q <= emit_id_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/rgit_dp.sv @@
// Datapath of the grapheme intern table: pool memories, staging, counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module rgit_dp #(
	parameter int POOL_ENTRIES   = 4096,
	parameter int MAX_CODEPOINTS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rgit_pkg::req_t req,
	input  wire rgit_pkg::cmd_t cmd,
	output rgit_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output rgit_pkg::rsp_t      rsp
);
	import rgit_pkg::*;

	localparam int LW  = $clog2(MAX_CODEPOINTS + 1);
	localparam int SAW = (MAX_CODEPOINTS > 1) ? $clog2(MAX_CODEPOINTS) : 1;
	localparam int EW  = $clog2(POOL_ENTRIES);
	localparam int UW  = $clog2(POOL_ENTRIES + 1);
	localparam int CAW = (POOL_ENTRIES * MAX_CODEPOINTS > 1) ?
		$clog2(POOL_ENTRIES * MAX_CODEPOINTS) : 1;
	localparam int BW  = $clog2(POOL_ENTRIES * MAX_CODEPOINTS + 1);
	localparam int CW  = (UW > ID_W) ? UW : ID_W;

	req_t             in_q;
	logic [UW-1:0]    used_q;
	logic             full_q;
	logic [LW-1:0]    count_q;
	logic             overlong_q;
	logic [UW-1:0]    e_q;
	logic [BW-1:0]    base_q;
	logic [LW-1:0]    k_q;
	logic [LW-1:0]    n_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [CP_W-1:0]  stg_rdata;
	logic [CP_W-1:0]  cp_rdata;
	logic [LW-1:0]    len_rdata;
	logic [REF_W-1:0] ref_rdata;
	logic [REF_W-1:0] ref_upd;
	logic [CAW-1:0]   cp_addr;
	logic [UW-1:0]    id_m1;
	logic             stg_room;
	logic             out_free;

	assign stg_room = (count_q < LW'(MAX_CODEPOINTS));
	assign cp_addr  = CAW'(base_q + BW'(k_q));
	assign id_m1    = UW'(in_q.entry_id - ID_W'(1));
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (in_q.op == OP_RETAIN) begin
			ref_upd = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + REF_W'(1);
		end else begin
			ref_upd = (ref_rdata == '0) ? ref_rdata : ref_rdata - REF_W'(1);
		end
	end

	rgit_ram #(.WIDTH(CP_W), .DEPTH(MAX_CODEPOINTS)) u_stg (
		.clk   (clk),
		.we    (cmd.stage_wr && stg_room),
		.waddr (count_q[SAW-1:0]),
		.wdata (in_q.codepoint),
		.re    (cmd.rd_stg),
		.raddr (k_q[SAW-1:0]),
		.rdata (stg_rdata)
	);

	rgit_ram #(.WIDTH(CP_W), .DEPTH(POOL_ENTRIES * MAX_CODEPOINTS)) u_cp (
		.clk   (clk),
		.we    (cmd.wr_cp),
		.waddr (cp_addr),
		.wdata (stg_rdata),
		.re    (cmd.rd_cp),
		.raddr (cp_addr),
		.rdata (cp_rdata)
	);

	rgit_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_len (
		.clk   (clk),
		.we    (cmd.wr_len_ref),
		.waddr (e_q[EW-1:0]),
		.wdata (count_q),
		.re    (cmd.rd_len),
		.raddr (e_q[EW-1:0]),
		.rdata (len_rdata)
	);

	rgit_ram #(.WIDTH(REF_W), .DEPTH(POOL_ENTRIES)) u_ref (
		.clk   (clk),
		.we    (cmd.wr_len_ref || cmd.wr_ref),
		.waddr (e_q[EW-1:0]),
		.wdata (cmd.wr_ref ? ref_upd : '0),
		.re    (cmd.rd_ref),
		.raddr (e_q[EW-1:0]),
		.rdata (ref_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			full_q      <= 1'b0;
			count_q     <= '0;
			overlong_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.used_inc) begin
				used_q <= used_q + UW'(1);
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.clr_staging) begin
				count_q    <= '0;
				overlong_q <= 1'b0;
			end else if (cmd.stage_wr) begin
				if (stg_room) begin
					count_q <= count_q + LW'(1);
				end else begin
					overlong_q <= 1'b1;
				end
			end
			if (cmd.emit || cmd.emit_get) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload and walk counters
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_q <= req;
		end
		if (cmd.e_clr) begin
			e_q    <= '0;
			base_q <= '0;
		end else if (cmd.e_next) begin
			e_q    <= e_q + UW'(1);
			base_q <= base_q + BW'(MAX_CODEPOINTS);
		end else if (cmd.e_load_id) begin
			e_q    <= id_m1;
			base_q <= BW'(id_m1) * BW'(MAX_CODEPOINTS);
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + LW'(1);
		end
		if (cmd.ld_n) begin
			n_q <= (len_rdata > LW'(MAX_CODEPOINTS)) ? LW'(MAX_CODEPOINTS) : len_rdata;
		end
		if (cmd.emit) begin
			rsp_q.status        <= cmd.emit_st;
			rsp_q.result_id     <= cmd.emit_id ? ID_W'(e_q + UW'(1)) : '0;
			rsp_q.length        <= '0;
			rsp_q.out_codepoint <= '0;
			rsp_q.result_last   <= 1'b1;
			rsp_q.full_seen     <= full_q;
		end else if (cmd.emit_get) begin
			rsp_q.status        <= ST_OK;
			rsp_q.result_id     <= '0;
			rsp_q.length        <= LEN_W'(n_q);
			rsp_q.out_codepoint <= cp_rdata;
			rsp_q.result_last   <= sts.k_last_get;
			rsp_q.full_seen     <= full_q;
		end
	end

	assign sts.op_intern  = (in_q.op == OP_INTERN);
	assign sts.op_get     = (in_q.op == OP_GET);
	assign sts.last       = in_q.last;
	assign sts.id_valid   = (in_q.entry_id != '0) && (CW'(in_q.entry_id) <= CW'(used_q));
	assign sts.overlong   = overlong_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.e_end      = (e_q == used_q);
	assign sts.used_full  = (used_q == UW'(POOL_ENTRIES));
	assign sts.len_eq     = (len_rdata == count_q);
	assign sts.cp_eq      = (cp_rdata == stg_rdata);
	assign sts.ref_zero   = (ref_rdata == '0);
	assign sts.k_last_int = ((k_q + LW'(1)) == count_q);
	assign sts.k_last_get = ((k_q + LW'(1)) == n_q);
	assign sts.n_zero     = (n_q == '0);
	assign sts.out_free   = out_free;
	assign sts.full       = full_q;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

@@ rtl/refcounted_grapheme_intern_table.sv @@
// Request transfers: a non-last intern codepoint is staged; an invalid id gets an invalid
// result; retain/release update the refcount; get reads the length, then emits each
// codepoint. Intern on the last codepoint walks the pool entry by entry and compares the
// codepoints of an entry of equal length; a new entry writes each codepoint, and a full pool
// adds a refcount scan of up to POOL_ENTRIES (4096) entries. Result stalls lengthen these.
// Reset (arst_n low): pool empty, staging empty, full flag clear; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "refcounted_grapheme_intern_table_macros.svh"
module refcounted_grapheme_intern_table #(
	parameter int POOL_ENTRIES   = 4096,
	parameter int MAX_CODEPOINTS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire rgit_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output rgit_pkg::rsp_t      rsp
);
	import rgit_pkg::*;

	// Command and status between sequencer and datapath.
	cmd_t cmd;
	sts_t sts;

	// The sequencer takes one request transfer at a time and steps the datapath
	// through the search, refcount scan, entry write, refcount update or readback.
	rgit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the pool memories, the staging buffer, and the result
	// register that lets a new request transfer while a result waits.
	rgit_dp #(
		.POOL_ENTRIES   (POOL_ENTRIES),
		.MAX_CODEPOINTS (MAX_CODEPOINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// A request transfer always leaves the block busy for the next cycle.
	`RGIT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "not busy")
	// The pool-full flag never clears once set.
	`RGIT_ASSERT_NEXT(a_full_sticky, sts.full, sts.full, "full flag dropped")
	// The pool never shrinks once it has filled.
	`RGIT_ASSERT_NEXT(a_pool_no_shrink, sts.used_full, sts.used_full, "pool size dropped")
	// A result is only loaded when the result register is free.
	`RGIT_ASSERT(a_no_overrun, !(cmd.emit || cmd.emit_get) || sts.out_free, "result overwritten")
endmodule
`default_nettype wire
